// ===== src/csv_field_tokenizer_core_defines.svh =====
// assertion macros shared by the csv tokenizer rtl
// expects signals named clk and rst_n in the module that uses them
`ifndef CSV_FIELD_TOKENIZER_CORE_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_CORE_DEFINES_SVH

// checked only while out of reset
`define CFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/cft_pkg.sv =====
// shared types for the csv field tokenizer: result kinds, field types and
// the per-request result group passed from the parser to the output queue
`default_nettype none

package cft_pkg;

  // most results one request can cause
  localparam int unsigned GROUP_MAX = 3;

  typedef enum logic [2:0] {
    KIND_CONTENT    = 3'd0,
    KIND_FIELD_END  = 3'd1,
    KIND_RECORD_END = 3'd2,
    KIND_TEXT_END   = 3'd3,
    KIND_ERROR      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    FT_STRING = 2'd0,
    FT_INT    = 2'd1,
    FT_DOUBLE = 2'd2,
    FT_BOOL   = 2'd3
  } ftype_t;

  // all results caused by one request; at most one content and one field end
  typedef struct packed {
    logic [1:0]                 cnt;
    kind_t [GROUP_MAX-1:0]      kinds;
    logic [7:0]                 content_byte;
    ftype_t                     field_type;
    logic signed [31:0]         int_value;
  } group_t;

endpackage

`default_nettype wire

// ===== src/cft_parser.sv =====
// csv parser: input register, phase/type state and the result group per request
// depends on cft_pkg and csv_field_tokenizer_core_defines.svh
`default_nettype none
`include "csv_field_tokenizer_core_defines.svh"

module cft_parser #(
  parameter int INT_WIDTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_text_byte,
  input  wire logic           in_end_of_text,
  input  wire logic           q_space,
  output logic                push,
  output cft_pkg::group_t     grp
);

  typedef enum logic [3:0] {
    PH_TEXT_START,
    PH_FIELD_START,
    PH_UNQ,
    PH_UNQ_QUOTE,
    PH_QUOTED,
    PH_QUOTED_Q,
    PH_AFTER_CLOSE,
    PH_LINE_SKIP,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    NC_START,
    NC_SIGN,
    NC_INT,
    NC_POINT,
    NC_FRAC,
    NC_EXP,
    NC_EXPSIGN,
    NC_DEAD
  } nclass_t;

  localparam logic [3:0] BM_START = 4'd0;
  localparam logic [3:0] BM_TRUE  = 4'd4;
  localparam logic [3:0] BM_FALSE = 4'd9;
  localparam logic [3:0] BM_DEAD  = 4'd15;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  // letters of "true" and "false" by match position
  function automatic logic [7:0] word_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd2:    ch = 8'h72;
      4'd3:    ch = 8'h75;
      4'd4:    ch = 8'h65;
      4'd6:    ch = 8'h61;
      4'd7:    ch = 8'h6C;
      4'd8:    ch = 8'h73;
      4'd9:    ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // order in which results of one request are listed
  function automatic cft_pkg::kind_t flag_kind(input int idx);
    cft_pkg::kind_t k;
    unique case (idx)
      0:       k = cft_pkg::KIND_CONTENT;
      1:       k = cft_pkg::KIND_FIELD_END;
      2:       k = cft_pkg::KIND_RECORD_END;
      3:       k = cft_pkg::KIND_ERROR;
      default: k = cft_pkg::KIND_TEXT_END;
    endcase
    return k;
  endfunction

  logic                 s1_valid_r, s1_valid_nxt;
  logic [7:0]           s1_byte_r;
  logic                 s1_eot_r;
  phase_t               ph_r, ph_nxt;
  nclass_t              nc_r, nc_nxt;
  logic [3:0]           bm_r, bm_nxt;
  logic [INT_WIDTH-1:0] mag_r, mag_nxt;
  logic                 neg_r, neg_nxt;

  logic                 go;
  logic [7:0]           c;
  logic                 start_fld;
  logic                 base_reset;
  nclass_t              nc_base, nc_cls;
  logic [3:0]           bm_base, bm_cls;
  logic [INT_WIDTH-1:0] mag_base, mag_cls;
  logic                 neg_base, neg_cls;
  logic                 digit, is_e;
  logic [7:0]           low;
  logic [INT_WIDTH-1:0] fe_signed;
  logic signed [31:0]   fe_int32;
  cft_pkg::ftype_t      fe_type;
  logic signed [31:0]   fe_val;
  logic                 unq, unq_q, aq;
  logic [4:0]           flags;
  logic [1:0]           cnt;

  // input register handshake
  assign go       = s1_valid_r && q_space;
  assign in_ready = !s1_valid_r || q_space;
  assign c        = s1_byte_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // a byte that opens a new field
  always_comb begin
    start_fld = 1'b0;
    if (!s1_eot_r) begin
      unique case (ph_r)
        PH_TEXT_START, PH_FIELD_START: start_fld = (c != CH_SPACE);
        PH_LINE_SKIP:                  start_fld = (c > CH_SPACE);
        default:                       start_fld = 1'b0;
      endcase
    end
  end

  // field state seen by this byte: cleared when a field opens
  assign base_reset = start_fld || (s1_eot_r && (ph_r == PH_FIELD_START));
  assign nc_base    = base_reset ? NC_START : nc_r;
  assign bm_base    = base_reset ? BM_START : bm_r;
  assign mag_base   = base_reset ? '0 : mag_r;
  assign neg_base   = base_reset ? 1'b0 : neg_r;

  // number syntax class
  assign digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_e  = (c == CH_LOWER_E) || (c == CH_UPPER_E);
  assign low   = c | CASE_BIT;

  always_comb begin
    nc_cls = NC_DEAD;
    unique case (nc_base)
      NC_START: begin
        if (c == CH_MINUS) begin
          nc_cls = NC_SIGN;
        end else if (digit) begin
          nc_cls = NC_INT;
        end
      end
      NC_SIGN:    nc_cls = digit ? NC_INT : NC_DEAD;
      NC_INT: begin
        if (digit) begin
          nc_cls = NC_INT;
        end else if (is_e) begin
          nc_cls = NC_EXP;
        end else if (c == CH_POINT) begin
          nc_cls = NC_POINT;
        end
      end
      NC_POINT:   nc_cls = digit ? NC_FRAC : NC_DEAD;
      NC_FRAC: begin
        if (digit) begin
          nc_cls = NC_FRAC;
        end else if (is_e) begin
          nc_cls = NC_EXP;
        end
      end
      NC_EXP:     nc_cls = ((c == CH_PLUS) || (c == CH_MINUS)) ? NC_EXPSIGN : NC_DEAD;
      NC_EXPSIGN: nc_cls = digit ? NC_EXPSIGN : NC_DEAD;
      NC_DEAD:    nc_cls = NC_DEAD;
    endcase
  end

  assign neg_cls = neg_base || ((nc_base == NC_START) && (c == CH_MINUS));

  // magnitude times ten plus digit, wrapping at INT_WIDTH bits
  assign mag_cls = ((nc_cls == NC_INT) && digit)
                 ? (mag_base << 3) + (mag_base << 1)
                   + {{(INT_WIDTH-4){1'b0}}, 4'(c - CH_ZERO)}
                 : mag_base;

  // true/false matcher
  always_comb begin
    priority if (bm_base == BM_START) begin
      if (low == CH_LOWER_T) begin
        bm_cls = 4'd1;
      end else if (low == CH_LOWER_F) begin
        bm_cls = 4'd5;
      end else begin
        bm_cls = BM_DEAD;
      end
    end else if (((bm_base >= 4'd1) && (bm_base <= 4'd3)) ||
                 ((bm_base >= 4'd5) && (bm_base <= 4'd8))) begin
      bm_cls = (low == word_char(bm_base + 4'd1)) ? bm_base + 4'd1 : BM_DEAD;
    end else begin
      bm_cls = BM_DEAD;
    end
  end

  // field end type and value
  assign fe_signed = neg_base ? (~mag_base + INT_WIDTH'(1)) : mag_base;

  generate
    if (INT_WIDTH >= 32) begin : g_trunc
      assign fe_int32 = fe_signed[31:0];
    end else begin : g_sext
      assign fe_int32 = {{(32-INT_WIDTH){fe_signed[INT_WIDTH-1]}}, fe_signed};
    end
  endgenerate

  always_comb begin
    priority if (bm_base == BM_TRUE) begin
      fe_type = cft_pkg::FT_BOOL;
      fe_val  = 32'sd1;
    end else if (bm_base == BM_FALSE) begin
      fe_type = cft_pkg::FT_BOOL;
      fe_val  = 32'sd0;
    end else if (nc_base == NC_INT) begin
      fe_type = cft_pkg::FT_INT;
      fe_val  = fe_int32;
    end else if ((nc_base == NC_FRAC) || (nc_base == NC_EXPSIGN)) begin
      fe_type = cft_pkg::FT_DOUBLE;
      fe_val  = 32'sd0;
    end else begin
      fe_type = cft_pkg::FT_STRING;
      fe_val  = 32'sd0;
    end
  end

  // phase transitions and results of one request
  always_comb begin
    ph_nxt  = ph_r;
    nc_nxt  = nc_r;
    bm_nxt  = bm_r;
    mag_nxt = mag_r;
    neg_nxt = neg_r;
    flags   = '0;
    unq     = 1'b0;
    unq_q   = 1'b0;
    aq      = 1'b0;
    if (s1_eot_r) begin
      unique case (ph_r)
        PH_FIELD_START, PH_UNQ, PH_UNQ_QUOTE, PH_QUOTED_Q, PH_AFTER_CLOSE: begin
          flags[1] = 1'b1;
          flags[2] = 1'b1;
        end
        PH_QUOTED: flags[3] = 1'b1;
        default:   flags[3] = 1'b0;
      endcase
      flags[4] = 1'b1;
      ph_nxt   = PH_TEXT_START;
      nc_nxt   = NC_START;
      bm_nxt   = BM_START;
      mag_nxt  = '0;
      neg_nxt  = 1'b0;
    end else begin
      unique case (ph_r)
        PH_TEXT_START: begin
          if (c == CH_SPACE) begin
            ph_nxt = PH_FIELD_START;
          end
        end
        PH_UNQ:       unq = 1'b1;
        PH_UNQ_QUOTE: begin
          unq   = 1'b1;
          unq_q = 1'b1;
        end
        PH_QUOTED: begin
          if (c == CH_QUOTE) begin
            ph_nxt = PH_QUOTED_Q;
          end else begin
            flags[0] = 1'b1;
          end
        end
        PH_QUOTED_Q: begin
          if (c == CH_QUOTE) begin
            flags[0] = 1'b1;
            ph_nxt   = PH_QUOTED;
          end else begin
            aq = 1'b1;
          end
        end
        PH_AFTER_CLOSE: aq = 1'b1;
        PH_FIELD_START, PH_LINE_SKIP: ph_nxt = ph_r;
        default: ph_nxt = PH_ERROR;
      endcase

      // field opening
      if (start_fld) begin
        nc_nxt  = NC_START;
        bm_nxt  = BM_START;
        mag_nxt = '0;
        neg_nxt = 1'b0;
        if (c == CH_QUOTE) begin
          nc_nxt = NC_DEAD;
          bm_nxt = BM_DEAD;
          ph_nxt = PH_QUOTED;
        end else begin
          unq = 1'b1;
        end
      end

      // byte of an unquoted field
      if (unq) begin
        priority if (c == CH_COMMA) begin
          flags[1] = 1'b1;
          ph_nxt   = PH_FIELD_START;
        end else if (c == CH_NEWLINE) begin
          flags[1] = 1'b1;
          flags[2] = 1'b1;
          ph_nxt   = PH_LINE_SKIP;
        end else if (c == CH_QUOTE) begin
          nc_nxt = NC_DEAD;
          bm_nxt = BM_DEAD;
          if (unq_q) begin
            ph_nxt = PH_UNQ;
          end else begin
            flags[0] = 1'b1;
            ph_nxt   = PH_UNQ_QUOTE;
          end
        end else begin
          flags[0] = 1'b1;
          nc_nxt   = nc_cls;
          bm_nxt   = bm_cls;
          mag_nxt  = mag_cls;
          neg_nxt  = neg_cls;
          ph_nxt   = PH_UNQ;
        end
      end

      // byte after a closing quote
      if (aq) begin
        priority if (c == CH_SPACE) begin
          ph_nxt = PH_AFTER_CLOSE;
        end else if (c == CH_COMMA) begin
          flags[1] = 1'b1;
          ph_nxt   = PH_FIELD_START;
        end else if (c == CH_NEWLINE) begin
          flags[1] = 1'b1;
          flags[2] = 1'b1;
          ph_nxt   = PH_LINE_SKIP;
        end else begin
          flags[3] = 1'b1;
          ph_nxt   = PH_ERROR;
        end
      end
    end
  end

  // pack the raised results in order
  always_comb begin
    cnt                = '0;
    grp.kinds          = '{default: cft_pkg::KIND_CONTENT};
    for (int i = 0; i < 5; i++) begin
      if (flags[i]) begin
        grp.kinds[cnt] = flag_kind(i);
        cnt            = cnt + 2'd1;
      end
    end
    grp.cnt          = cnt;
    grp.content_byte = c;
    grp.field_type   = fe_type;
    grp.int_value    = fe_val;
  end

  assign push = go && (cnt != 2'd0);

  // input register and parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      ph_r       <= PH_TEXT_START;
      nc_r       <= NC_START;
      bm_r       <= BM_START;
      mag_r      <= '0;
      neg_r      <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (go) begin
        ph_r  <= ph_nxt;
        nc_r  <= nc_nxt;
        bm_r  <= bm_nxt;
        mag_r <= mag_nxt;
        neg_r <= neg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_text_byte;
      s1_eot_r  <= in_end_of_text;
    end
  end

  `CFT_ASSERT(p_end_resets_state, go && s1_eot_r |=> ph_r == PH_TEXT_START && nc_r == NC_START && bm_r == BM_START, "state not back to text start after text end")
  `CFT_ASSERT(p_error_is_quiet, go && !s1_eot_r && ph_r == PH_ERROR |-> !push, "result raised while in error phase")
  `CFT_ASSERT(p_end_closes_group, push && s1_eot_r |-> grp.kinds[grp.cnt - 2'd1] == cft_pkg::KIND_TEXT_END, "text end request not closed by a text end")

endmodule

`default_nettype wire

// ===== src/cft_out_queue.sv =====
// result queue: holds result groups and hands out one result per cycle while out_ready is high
// depends on cft_pkg and csv_field_tokenizer_core_defines.svh
`default_nettype none
`include "csv_field_tokenizer_core_defines.svh"

module cft_out_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire cft_pkg::group_t    push_grp,
  output logic                    space,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_kind,
  output logic [7:0]              out_content_byte,
  output logic [1:0]              out_field_type,
  output logic signed [31:0]      out_int_value,
  output logic                    out_last_of_run
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  cft_pkg::group_t    mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   q_cnt_r;
  logic [1:0]         sub_r;
  cft_pkg::group_t    head;
  cft_pkg::kind_t     kind;
  logic               last;
  logic               take;
  logic               pop;

  assign head      = mem_r[rd_ptr_r];
  assign out_valid = (q_cnt_r != '0);
  assign space     = (q_cnt_r != FULL);
  assign kind      = head.kinds[sub_r];
  assign last      = (sub_r == head.cnt - 2'd1);
  assign take      = out_valid && out_ready;
  assign pop       = take && last;

  // result fields, zero where they do not apply
  assign out_kind         = kind;
  assign out_content_byte = (kind == cft_pkg::KIND_CONTENT) ? head.content_byte : 8'h00;
  assign out_field_type   = (kind == cft_pkg::KIND_FIELD_END) ? head.field_type
                                                              : cft_pkg::FT_STRING;
  assign out_int_value    = (kind == cft_pkg::KIND_FIELD_END) ? head.int_value : 32'sd0;
  assign out_last_of_run  = last;

  // pointers, fill count and position within the head group
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
      sub_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   q_cnt_r <= q_cnt_r + CNT_W'(1);
        2'b01:   q_cnt_r <= q_cnt_r - CNT_W'(1);
        default: q_cnt_r <= q_cnt_r;
      endcase
      if (take) begin
        sub_r <= pop ? 2'd0 : sub_r + 2'd1;
      end
    end
  end

  // group storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

  `CFT_ASSERT(q_no_overflow, push |-> space, "group written into a full queue")
  `CFT_ASSERT(q_sub_in_range, out_valid |-> sub_r < head.cnt, "result position beyond head group")
  `CFT_ASSERT_ALWAYS(q_reset_empty, !rst_n |=> q_cnt_r == '0 && sub_r == 2'd0, "queue not empty after reset")

endmodule

`default_nettype wire

// ===== src/csv_field_tokenizer_core.sv =====
// csv field tokenizer top level: parser plus result queue
// depends on cft_pkg, cft_parser and cft_out_queue
//
// in channel: one request per text byte (in_text_byte) or one end-of-text
// request (in_end_of_text high, byte ignored), valid/ready handshake.
// out channel: zero to three results per request: content byte, field
// end (with type and int value), record end, text end or error;
// out_last_of_run marks the last result caused by one input request.
// throughput: one input request per cycle while the queue has space. a request
// registers into the parser stage, its results are written into a four-group
// queue once that has space, and the first of them shows on out_valid after
// that write once the groups ahead of it have been handed out.
// requests with up to three results (field end, record end, text end) hand
// them out on consecutive cycles while out_ready is high; the queue absorbs
// these bursts, so the sustained rate is set by the single output port of
// one result per cycle. a stalled receiver fills the queue, then the parser
// stage, then in_ready drops; nothing is lost. synchronous reset (rst_n low)
// empties the queue and parser stage and returns the parser to the start of
// a text. after a text end the parser is back in its reset state.
`default_nettype none

module csv_field_tokenizer_core #(
  parameter int INT_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_text_byte,
  input  wire logic         in_end_of_text,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [2:0]        out_kind,
  output logic [7:0]        out_content_byte,
  output logic [1:0]        out_field_type,
  output logic signed [31:0] out_int_value,
  output logic              out_last_of_run
);

  logic            q_space;
  logic            push;
  cft_pkg::group_t grp;

  // byte parser and type inference
  cft_parser #(
    .INT_WIDTH (INT_WIDTH)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .q_space        (q_space),
    .push           (push),
    .grp            (grp)
  );

  // result queue and serializer
  cft_out_queue u_out_queue (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .push_grp         (grp),
    .space            (q_space),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_content_byte (out_content_byte),
    .out_field_type   (out_field_type),
    .out_int_value    (out_int_value),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

`default_nettype wire
